[rtl/awcd_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// awcd_pkg
// Shared types and constants for the write-back cache directory: request
// operation codes, field widths and the controller/datapath interface.
// -----------------------------------------------------------------------------
package awcd_pkg;

   // Field widths fixed by the request and response formats
   localparam int OP_W      = 2;
   localparam int CLUSTER_W = 32;
   localparam int SLOT_W    = 6;

   // Default directory depth (1 to 64 slots)
   localparam int DEFAULT_ENTRIES = 16;

   // Request operation codes
   localparam logic [OP_W-1:0] OP_READ       = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_FULL = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE_PART = 2'd2;
   localparam logic [OP_W-1:0] OP_FLUSH      = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // latch request, register tag match vector
      logic resolve;     // finish lookup: load response, update directory
      logic flush_step;  // report one slot of a flush and advance the scan
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;    // response register can take a new response
      logic scan_last;   // flush scan sits on the final slot
   } status_type;

endpackage : awcd_pkg
`default_nettype wire

[rtl/awcd_ctrl.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// awcd_ctrl
// Controller state machine: accepts one request at a time, sequences the
// lookup resolve step or the flush scan, and paces both on the response
// register.
// -----------------------------------------------------------------------------
module awcd_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [awcd_pkg::OP_W-1:0]   req_operation,
   output logic                             req_stall,
   input  wire awcd_pkg::status_type        status,
   output awcd_pkg::cmd_type                cmd
);
   import awcd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // Take a request only while idle
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.capture     = 1'b0;
      cmd.resolve     = 1'b0;
      cmd.flush_step  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = (req_operation == OP_FLUSH) ? S_FLUSH : S_MATCH;
            end
         end
         S_MATCH: begin
            if (status.out_free) begin
               cmd.resolve = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_step = 1'b1;
               if (status.scan_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : awcd_ctrl
`default_nettype wire

[rtl/awcd_datapath.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// awcd_datapath
// Directory storage (valid, dirty, tag per slot), FIFO fill pointer, tag
// match vector, flush scan counter and the response register.
// -----------------------------------------------------------------------------
module awcd_datapath #(
   parameter int ENTRIES = awcd_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [awcd_pkg::OP_W-1:0]      req_operation,
   input  wire logic [awcd_pkg::CLUSTER_W-1:0] req_cluster,
   input  wire awcd_pkg::cmd_type              cmd,
   output awcd_pkg::status_type                status,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [awcd_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                                rsp_hit,
   output logic                                rsp_writeback,
   output logic [awcd_pkg::CLUSTER_W-1:0]      rsp_writeback_cluster,
   output logic                                rsp_fetch,
   output logic                                rsp_last
);
   import awcd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Directory state
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   dirty_ff;
   logic [CLUSTER_W-1:0] tag_ff [ENTRIES];
   logic [IDX_W-1:0]     fill_ff;
   logic [IDX_W-1:0]     fill_in;

   // Captured request and lookup
   logic [OP_W-1:0]      op_ff;
   logic [CLUSTER_W-1:0] cluster_ff;
   logic [ENTRIES-1:0]   match_ff;
   logic [ENTRIES-1:0]   match_in;
   logic [IDX_W-1:0]     scan_ff;

   // Response register
   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_wb_ff;
   logic [CLUSTER_W-1:0] rsp_wbc_ff;
   logic                 rsp_fetch_ff;
   logic                 rsp_last_ff;

   logic                 hit_any;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic                 rd_valid;
   logic                 rd_dirty;
   logic [CLUSTER_W-1:0] rd_tag;
   logic                 victim_wb;
   logic                 is_write;
   logic                 out_load;

   // Compare the requested cluster against every slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == req_cluster);
      end
   end

   // Pick the lowest matching slot
   always_comb begin
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any  = |match_ff;
   assign is_write = (op_ff != OP_READ);
   assign out_load = cmd.resolve || cmd.flush_step;

   // Read the victim slot on a lookup, the scanned slot on a flush
   assign rd_idx    = (op_ff == OP_FLUSH) ? scan_ff : fill_ff;
   assign rd_valid  = valid_ff[rd_idx];
   assign rd_dirty  = dirty_ff[rd_idx];
   assign rd_tag    = tag_ff[rd_idx];
   assign victim_wb = rd_valid && rd_dirty;

   assign fill_in = (fill_ff == LAST_IDX) ? '0 : fill_ff + 1'b1;

   // Capture request and match vector
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         cluster_ff <= req_cluster;
         match_ff   <= match_in;
      end
   end

   // Advance fill pointer and flush scan
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         scan_ff <= '0;
      end else begin
         if (cmd.resolve && !hit_any) begin
            fill_ff <= fill_in;
         end
         if (cmd.capture) begin
            scan_ff <= '0;
         end else if (cmd.flush_step) begin
            scan_ff <= (scan_ff == LAST_IDX) ? '0 : scan_ff + 1'b1;
         end
      end
   end

   // Set valid on install
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.resolve && !hit_any) begin
         valid_ff[fill_ff] <= 1'b1;
      end
   end

   // Mark dirty on write, clear on flush
   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         if (hit_any) begin
            if (is_write) begin
               dirty_ff[hit_idx] <= 1'b1;
            end
         end else begin
            dirty_ff[fill_ff] <= is_write;
         end
      end else if (cmd.flush_step && rd_valid) begin
         dirty_ff[scan_ff] <= 1'b0;
      end
   end

   // Install tag on miss
   always_ff @(posedge clock) begin
      if (cmd.resolve && !hit_any) begin
         tag_ff[fill_ff] <= cluster_ff;
      end
   end

   // Response handshake: load, then drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.flush_step) begin
         rsp_slot_ff  <= SLOT_W'(scan_ff);
         rsp_hit_ff   <= 1'b0;
         rsp_wb_ff    <= rd_valid;
         rsp_wbc_ff   <= rd_valid ? rd_tag : '0;
         rsp_fetch_ff <= 1'b0;
         rsp_last_ff  <= (scan_ff == LAST_IDX);
      end else if (cmd.resolve) begin
         rsp_last_ff <= 1'b1;
         if (hit_any) begin
            rsp_slot_ff  <= SLOT_W'(hit_idx);
            rsp_hit_ff   <= 1'b1;
            rsp_wb_ff    <= 1'b0;
            rsp_wbc_ff   <= '0;
            rsp_fetch_ff <= 1'b0;
         end else begin
            rsp_slot_ff  <= SLOT_W'(fill_ff);
            rsp_hit_ff   <= 1'b0;
            rsp_wb_ff    <= victim_wb;
            rsp_wbc_ff   <= victim_wb ? rd_tag : '0;
            rsp_fetch_ff <= (op_ff != OP_WRITE_FULL);
         end
      end
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.scan_last = (scan_ff == LAST_IDX);

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_writeback         = rsp_wb_ff;
   assign rsp_writeback_cluster = rsp_wbc_ff;
   assign rsp_fetch             = rsp_fetch_ff;
   assign rsp_last              = rsp_last_ff;

endmodule : awcd_datapath
`default_nettype wire

[rtl/assoc_writeback_cache_directory_unit.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// assoc_writeback_cache_directory_unit
// Fully associative write-back cluster cache directory with FIFO replacement.
// -----------------------------------------------------------------------------
// One request is handled at a time. A read, full write or partial write goes
// in two steps: the accept cycle compares the cluster against every slot and
// registers the match vector; the resolve step, taken once the response
// register is free, resolves hit or miss, updates the directory and loads the
// single response register. A flush gives one response per slot, lowest slot
// first, paced by the same response register. A stall on the response side
// holds back the resolve step and each flush step. A new request is taken
// as soon as the last response is loaded, while it still waits to be taken.
// -----------------------------------------------------------------------------
module assoc_writeback_cache_directory_unit #(
   parameter int ENTRIES = awcd_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [awcd_pkg::OP_W-1:0]      req_operation,
   input  wire logic [awcd_pkg::CLUSTER_W-1:0] req_cluster,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [awcd_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                                rsp_hit,
   output logic                                rsp_writeback,
   output logic [awcd_pkg::CLUSTER_W-1:0]      rsp_writeback_cluster,
   output logic                                rsp_fetch,
   output logic                                rsp_last
);
   import awcd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence requests
   awcd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Hold directory and responses
   awcd_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_operation         (req_operation),
      .req_cluster           (req_cluster),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot              (rsp_slot),
      .rsp_hit               (rsp_hit),
      .rsp_writeback         (rsp_writeback),
      .rsp_writeback_cluster (rsp_writeback_cluster),
      .rsp_fetch             (rsp_fetch),
      .rsp_last              (rsp_last)
   );

endmodule : assoc_writeback_cache_directory_unit
`default_nettype wire

[rtl/awcd_checker.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// awcd_checker
// Port-level checks for the cache directory, bound to the top level.
// -----------------------------------------------------------------------------
module awcd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [awcd_pkg::SLOT_W-1:0]    rsp_slot,
   input wire logic                           rsp_hit,
   input wire logic                           rsp_writeback,
   input wire logic [awcd_pkg::CLUSTER_W-1:0] rsp_writeback_cluster,
   input wire logic                           rsp_fetch,
   input wire logic                           rsp_last
);
   import awcd_pkg::*;

   // A request in flight blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous request in flight");

   // A hit neither writes back nor fetches, and ends the request
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_writeback && !rsp_fetch && rsp_last)
      else $error("hit response reports writeback or fetch");

   // No write-back means a zero cluster
   a_wbc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writeback |-> rsp_writeback_cluster == '0)
      else $error("writeback cluster nonzero without writeback");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit)
         && $stable(rsp_writeback) && $stable(rsp_writeback_cluster)
         && $stable(rsp_fetch) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule : awcd_checker

bind assoc_writeback_cache_directory_unit awcd_checker u_awcd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_slot              (rsp_slot),
   .rsp_hit               (rsp_hit),
   .rsp_writeback         (rsp_writeback),
   .rsp_writeback_cluster (rsp_writeback_cluster),
   .rsp_fetch             (rsp_fetch),
   .rsp_last              (rsp_last)
);
`default_nettype wire

[tb/sv/awcd_directory_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awcd_directory_checker
// Watches the request and response channels of the cache directory. It keeps
// its own copy of the slot tags, valid and dirty bits and the fill pointer,
// works out the responses of every accepted request and compares each taken
// response field by field with the oldest one still due.
// -----------------------------------------------------------------------------
module awcd_directory_checker #(
   parameter int ENTRIES = awcd_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [awcd_pkg::OP_W-1:0]      req_operation,
   input  wire logic [awcd_pkg::CLUSTER_W-1:0] req_cluster,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [awcd_pkg::SLOT_W-1:0]    rsp_slot,
   input  wire logic                           rsp_hit,
   input  wire logic                           rsp_writeback,
   input  wire logic [awcd_pkg::CLUSTER_W-1:0] rsp_writeback_cluster,
   input  wire logic                           rsp_fetch,
   input  wire logic                           rsp_last,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   import awcd_pkg::*;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic                 hit;
      logic                 writeback;
      logic [CLUSTER_W-1:0] wb_cluster;
      logic                 fetch;
      logic                 last;
   } dir_rsp_type;

   // Shadow directory
   logic                 dir_valid [ENTRIES];
   logic                 dir_dirty [ENTRIES];
   logic [CLUSTER_W-1:0] dir_tag   [ENTRIES];
   int                   fill_ptr;

   dir_rsp_type due_rsp [$];
   int          fail_total = 0;

   // Work out the responses of one request and update the shadow directory
   task automatic resolve_request(input logic [OP_W-1:0] op,
                                  input logic [CLUSTER_W-1:0] cl);
      dir_rsp_type r;
      int          hit_slot;
      int          s;
      if (op == OP_FLUSH) begin
         for (int i = 0; i < ENTRIES; i++) begin
            r            = '0;
            r.slot       = SLOT_W'(i);
            r.writeback  = dir_valid[i];
            r.wb_cluster = dir_valid[i] ? dir_tag[i] : '0;
            r.last       = (i == ENTRIES - 1);
            due_rsp.push_back(r);
            if (dir_valid[i])
               dir_dirty[i] = 1'b0;
         end
      end else begin
         r        = '0;
         r.last   = 1'b1;
         hit_slot = -1;
         // lowest matching slot wins
         for (int i = ENTRIES - 1; i >= 0; i--)
            if (dir_valid[i] && dir_tag[i] == cl)
               hit_slot = i;
         if (hit_slot >= 0) begin
            r.slot = SLOT_W'(hit_slot);
            r.hit  = 1'b1;
            if (op != OP_READ)
               dir_dirty[hit_slot] = 1'b1;
         end else begin
            // take the slot under the fill pointer, write back a dirty victim
            s            = fill_ptr;
            r.slot       = SLOT_W'(s);
            r.writeback  = dir_valid[s] && dir_dirty[s];
            r.wb_cluster = r.writeback ? dir_tag[s] : '0;
            r.fetch      = (op != OP_WRITE_FULL);
            dir_valid[s] = 1'b1;
            dir_dirty[s] = (op != OP_READ);
            dir_tag[s]   = cl;
            fill_ptr     = (s + 1) % ENTRIES;
         end
         due_rsp.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [CLUSTER_W-1:0] want,
                              input logic [CLUSTER_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_total++;
      end
   endtask

   // Check taken responses first, then predict the accepted request
   always @(posedge clock) begin
      dir_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_tag[i]   = '0;
         end
         fill_ptr = 0;
         due_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               $error("response taken with none due: slot %0d", rsp_slot);
               fail_total++;
            end else begin
               want = due_rsp.pop_front();
               check_field("slot", CLUSTER_W'(want.slot), CLUSTER_W'(rsp_slot));
               check_field("hit", CLUSTER_W'(want.hit), CLUSTER_W'(rsp_hit));
               check_field("writeback", CLUSTER_W'(want.writeback),
                           CLUSTER_W'(rsp_writeback));
               check_field("writeback_cluster", want.wb_cluster, rsp_writeback_cluster);
               check_field("fetch", CLUSTER_W'(want.fetch), CLUSTER_W'(rsp_fetch));
               check_field("last", CLUSTER_W'(want.last), CLUSTER_W'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            resolve_request(req_operation, req_cluster);
      end
      mismatch_count <= fail_total;
      outstanding    <= due_rsp.size();
   end

endmodule : awcd_directory_checker

[tb/sv/assoc_writeback_cache_directory_unit_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// assoc_writeback_cache_directory_unit_tb
// Drives the cache directory with a directed set of lookups, misses and
// flushes, then with random requests drawn mostly from a small pool of hot
// clusters so that hits, evictions and dirty write-backs are frequent. The
// sender runs in random bursts, the response side stalls on its own pattern,
// and a checker beside the block predicts and compares every response.
// -----------------------------------------------------------------------------
module assoc_writeback_cache_directory_unit_tb;
   import awcd_pkg::*;

   localparam int ENTRIES     = DEFAULT_ENTRIES;
   localparam int RAND_ITEMS  = 158;
   localparam int POOL_SIZE   = 24;

   // Response stall patterns
   localparam int STALL_NONE   = 0;
   localparam int STALL_SPARSE = 1;
   localparam int STALL_DENSE  = 2;
   localparam int STALL_RUNS   = 3;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic [OP_W-1:0]      req_operation = OP_READ;
   logic [CLUSTER_W-1:0] req_cluster   = '0;
   logic                 rsp_stall     = 1'b0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_hit;
   logic                 rsp_writeback;
   logic [CLUSTER_W-1:0] rsp_writeback_cluster;
   logic                 rsp_fetch;
   logic                 rsp_last;

   int mismatch_count;
   int outstanding;

   int                   burst_left;
   int                   stall_mode = STALL_NONE;
   int                   mode_left  = 0;
   int                   stall_run  = 0;
   logic [CLUSTER_W-1:0] hot_clusters [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assoc_writeback_cache_directory_unit #(.ENTRIES(ENTRIES)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_cluster           (req_cluster),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot              (rsp_slot),
      .rsp_hit               (rsp_hit),
      .rsp_writeback         (rsp_writeback),
      .rsp_writeback_cluster (rsp_writeback_cluster),
      .rsp_fetch             (rsp_fetch),
      .rsp_last              (rsp_last)
   );

   awcd_directory_checker #(.ENTRIES(ENTRIES)) u_dir_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_cluster           (req_cluster),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot              (rsp_slot),
      .rsp_hit               (rsp_hit),
      .rsp_writeback         (rsp_writeback),
      .rsp_writeback_cluster (rsp_writeback_cluster),
      .rsp_fetch             (rsp_fetch),
      .rsp_last              (rsp_last),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding)
   );

   // Stall responses: switch between no stall, sparse, dense and long runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
            mode_left  <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_SPARSE: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_DENSE: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if (stall_run > 0) begin
                  rsp_stall <= 1'b1;
                  stall_run <= stall_run - 1;
               end else begin
                  rsp_stall <= 1'b0;
                  stall_run <= ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
               end
            end
         endcase
      end
   end

   // Present one request, hold it until taken, then close the burst if due
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [CLUSTER_W-1:0] cl);
      logic taken;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_cluster   <= cl;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // Drop the request line and hold until every due response has come
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   function automatic logic [CLUSTER_W-1:0] pick_cluster();
      if ($urandom_range(0, 9) < 7)
         return hot_clusters[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [OP_W-1:0] pick_operation();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return OP_FLUSH;
      if (r < 8)
         return OP_READ;
      if (r < 14)
         return OP_WRITE_FULL;
      return OP_WRITE_PART;
   endfunction

   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         hot_clusters[i] = $urandom;
      hot_clusters[0] = '0;
      hot_clusters[1] = '1;
      burst_left = $urandom_range(1, 30);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty flush, misses of each kind, hits, double flush
      send_request(OP_FLUSH,      '0);
      send_request(OP_READ,       32'h0000_0000);
      send_request(OP_WRITE_FULL, 32'hFFFF_FFFF);
      send_request(OP_WRITE_PART, 32'h5A5A_5A5A);
      send_request(OP_READ,       32'h0000_0000);
      send_request(OP_WRITE_PART, 32'hFFFF_FFFF);
      send_request(OP_WRITE_FULL, 32'h0000_0000);
      send_request(OP_READ,       32'hA5A5_A5A5);
      send_request(OP_FLUSH,      32'hFFFF_FFFF);
      send_request(OP_FLUSH,      '0);
      send_request(OP_WRITE_PART, 32'hA5A5_A5A5);
      send_request(OP_READ,       32'h0000_0000);
      wait_for_drain();

      // Random traffic, with one full drain halfway through
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 2)
            wait_for_drain();
         send_request(pick_operation(), pick_cluster());
      end
      wait_for_drain();
      repeat (ENTRIES + 24) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule : assoc_writeback_cache_directory_unit_tb

[filelist.f]
rtl/awcd_pkg.sv
rtl/awcd_ctrl.sv
rtl/awcd_datapath.sv
rtl/assoc_writeback_cache_directory_unit.sv
rtl/awcd_checker.sv
tb/sv/awcd_directory_checker.sv
tb/sv/assoc_writeback_cache_directory_unit_tb.sv
